// ----- src/athd_pkg.sv -----
// athd_pkg: widths, register codes, reset values and control structs for the
// averaged threshold hit detector; used by every module and interface in src
`default_nettype none

package athd_pkg;

  localparam int LANES     = 5;
  localparam int N_SENSORS = 5;
  localparam int N_SAMPLES = 10;

  localparam int SAMPLE_W = 10;
  localparam int THR_W    = 10;
  localparam int CNT_W    = 4;
  localparam int SUM_W    = 14;
  localparam int LIMIT_W  = THR_W + CNT_W;
  localparam int TIMER_W  = 16;
  localparam int IDX_W    = 3;
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;

  localparam logic [TIMER_W-1:0] TIMER_MAX = '1;
  localparam logic [TIMER_W-1:0] HOLDOFF_RESET = 16'd1000;

  localparam logic [LANES-1:0][THR_W-1:0] THR_RESET = {
    10'd340, 10'd260, 10'd340, 10'd260, 10'd140
  };

  typedef enum logic [2:0] {
    REG_THRESHOLD_0 = 3'd0,
    REG_THRESHOLD_1 = 3'd1,
    REG_THRESHOLD_2 = 3'd2,
    REG_THRESHOLD_3 = 3'd3,
    REG_THRESHOLD_4 = 3'd4,
    REG_HOLDOFF_MS  = 3'd5
  } reg_idx_t;

  typedef enum logic {
    CMD_FRAME = 1'b0,
    CMD_TICK  = 1'b1
  } cmd_t;

  typedef struct packed {
    logic [LANES-1:0][THR_W-1:0] threshold;
    logic [TIMER_W-1:0]          holdoff_ms;
  } cfg_t;

  typedef struct packed {
    logic add;
    logic clear;
  } lane_ctrl_t;

endpackage

`default_nettype wire

// ----- src/athd_frame_if.sv -----
// athd_frame_if: request channel carrying a command and one frame of samples
// depends on athd_pkg
`default_nettype none

interface athd_frame_if;
  logic                           valid;
  logic                           ready;
  logic                           cmd;
  logic [athd_pkg::SAMPLE_W-1:0]  sample_0;
  logic [athd_pkg::SAMPLE_W-1:0]  sample_1;
  logic [athd_pkg::SAMPLE_W-1:0]  sample_2;
  logic [athd_pkg::SAMPLE_W-1:0]  sample_3;
  logic [athd_pkg::SAMPLE_W-1:0]  sample_4;

  modport source (
    output valid, cmd, sample_0, sample_1, sample_2, sample_3, sample_4,
    input  ready
  );
  modport sink (
    input  valid, cmd, sample_0, sample_1, sample_2, sample_3, sample_4,
    output ready
  );
endinterface

`default_nettype wire

// ----- src/athd_result_if.sv -----
// athd_result_if: result channel carrying the hit flag and first sensor index
// depends on athd_pkg
`default_nettype none

interface athd_result_if;
  logic                        valid;
  logic                        ready;
  logic                        hit;
  logic [athd_pkg::IDX_W-1:0]  first_sensor;

  modport source (
    output valid, hit, first_sensor,
    input  ready
  );
  modport sink (
    input  valid, hit, first_sensor,
    output ready
  );
endinterface

`default_nettype wire

// ----- src/athd_regs.sv -----
// athd_regs: apb configuration registers (thresholds and holdoff)
// depends on athd_pkg
`default_nettype none

module athd_regs (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [athd_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [athd_pkg::DATA_W-1:0]  pwdata,
  output      logic [athd_pkg::DATA_W-1:0]  prdata,
  output      logic                         pready,
  output      athd_pkg::cfg_t               cfg
);

  logic [2:0] idx;
  logic       wr;

  assign idx    = paddr[4:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold  <= athd_pkg::THR_RESET;
      cfg.holdoff_ms <= athd_pkg::HOLDOFF_RESET;
    end else if (wr) begin
      case (idx)
        athd_pkg::REG_THRESHOLD_0,
        athd_pkg::REG_THRESHOLD_1,
        athd_pkg::REG_THRESHOLD_2,
        athd_pkg::REG_THRESHOLD_3,
        athd_pkg::REG_THRESHOLD_4: begin
          cfg.threshold[idx] <= pwdata[athd_pkg::THR_W-1:0];
        end
        athd_pkg::REG_HOLDOFF_MS: begin
          cfg.holdoff_ms <= pwdata[athd_pkg::TIMER_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      athd_pkg::REG_THRESHOLD_0,
      athd_pkg::REG_THRESHOLD_1,
      athd_pkg::REG_THRESHOLD_2,
      athd_pkg::REG_THRESHOLD_3,
      athd_pkg::REG_THRESHOLD_4: begin
        prdata = athd_pkg::DATA_W'(cfg.threshold[idx]);
      end
      athd_pkg::REG_HOLDOFF_MS: begin
        prdata = athd_pkg::DATA_W'(cfg.holdoff_ms);
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- src/athd_lane.sv -----
// athd_lane: one sensor's window accumulator and limit compare
// depends on athd_pkg
`default_nettype none

module athd_lane (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire athd_pkg::lane_ctrl_t           ctrl,
  input  wire logic [athd_pkg::SAMPLE_W-1:0]  sample,
  input  wire logic [athd_pkg::THR_W-1:0]     threshold,
  output      logic                           over
);

  logic [athd_pkg::SUM_W-1:0]   sum;
  logic [athd_pkg::SUM_W-1:0]   sum_next;
  logic [athd_pkg::LIMIT_W-1:0] limit;

  // sum wraps at its width
  assign sum_next = sum + athd_pkg::SUM_W'(sample);
  assign limit    = athd_pkg::LIMIT_W'(threshold)
                  * athd_pkg::LIMIT_W'(athd_pkg::N_SAMPLES);
  assign over     = athd_pkg::LIMIT_W'(sum_next) > limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
    end else if (ctrl.add) begin
      sum <= ctrl.clear ? '0 : sum_next;
    end
  end

endmodule

`default_nettype wire

// ----- src/athd_merge.sv -----
// athd_merge: window counter, holdoff timer, lowest-lane pick and result register
// depends on athd_pkg and athd_result_if
`default_nettype none

module athd_merge (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          accept,
  input  wire logic                          cmd,
  input  wire logic [athd_pkg::LANES-1:0]    over,
  input  wire logic [athd_pkg::TIMER_W-1:0]  holdoff_ms,
  output      athd_pkg::lane_ctrl_t          lane_ctrl,
  output      logic                          accept_ready,
  athd_result_if.source                      result
);

  logic [athd_pkg::CNT_W-1:0]   frame_count;
  logic [athd_pkg::CNT_W-1:0]   frame_count_next;
  logic [athd_pkg::TIMER_W-1:0] timer;
  logic                         frame_acc;
  logic                         tick_acc;
  logic                         done;
  logic                         any_over;
  logic                         fire;
  logic [athd_pkg::IDX_W-1:0]   first;

  assign frame_acc        = accept && (cmd == athd_pkg::CMD_FRAME);
  assign tick_acc         = accept && (cmd == athd_pkg::CMD_TICK);
  assign frame_count_next = frame_count + 1'b1;
  assign done             = frame_count_next >= athd_pkg::CNT_W'(athd_pkg::N_SAMPLES);
  assign any_over         = |over;
  assign fire             = frame_acc && done && (timer >= holdoff_ms) && any_over;
  assign accept_ready     = !result.valid || result.ready;

  assign lane_ctrl.add   = frame_acc;
  assign lane_ctrl.clear = done;

  always_comb begin
    first = '0;
    for (int i = athd_pkg::LANES - 1; i >= 0; i--) begin
      if (over[i]) begin
        first = athd_pkg::IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count         <= '0;
      timer               <= '0;
      result.valid        <= 1'b0;
      result.hit          <= 1'b0;
      result.first_sensor <= '0;
    end else begin
      if (frame_acc) begin
        frame_count <= done ? '0 : frame_count_next;
      end
      if (tick_acc && (timer != athd_pkg::TIMER_MAX)) begin
        timer <= timer + 1'b1;
      end else if (fire) begin
        timer <= '0;
      end
      if (frame_acc && done) begin
        result.valid        <= 1'b1;
        result.hit          <= fire;
        result.first_sensor <= fire ? first : '0;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_timer_cleared_on_hit: assert property (@(posedge clk) disable iff (rst)
    fire |=> timer == '0)
    else $error("holdoff timer not cleared after reported hit");

  a_timer_monotonic: assert property (@(posedge clk) disable iff (rst)
    !fire |=> timer >= $past(timer))
    else $error("holdoff timer decreased without a hit");

  a_no_hit_zero_index: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.hit |-> result.first_sensor == '0)
    else $error("first sensor nonzero on a miss");

  a_stall_only_on_held_result: assert property (@(posedge clk) disable iff (rst)
    !accept_ready |-> result.valid && !result.ready)
    else $error("input stalled without a held result");
`endif

endmodule

`default_nettype wire

// ----- src/averaged_threshold_hit_detector.sv -----
// averaged_threshold_hit_detector: top level, five accumulate-and-compare lanes
// merged into one result per window of N_SAMPLES frames; one request per cycle unless stalled
// result is valid in the cycle after the request that completes a window
// input stalls only while a result is held and the sink is not ready
// reset clears sums, frame count, holdoff timer and result valid; thresholds
// return to 140,260,340,260,340 and holdoff to 1000; depends on athd_pkg
`default_nettype none

module averaged_threshold_hit_detector (
  input  wire logic                         clk,
  input  wire logic                         rst,
  athd_frame_if.sink                        frame,
  athd_result_if.source                     result,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [athd_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [athd_pkg::DATA_W-1:0]  pwdata,
  output      logic [athd_pkg::DATA_W-1:0]  prdata,
  output      logic                         pready
);

  athd_pkg::cfg_t                                  cfg;
  athd_pkg::lane_ctrl_t                            lane_ctrl;
  logic [athd_pkg::LANES-1:0][athd_pkg::SAMPLE_W-1:0] samples;
  logic [athd_pkg::LANES-1:0]                      over;
  logic                                            accept_ready;
  logic                                            accept;

  assign samples[0]  = frame.sample_0;
  assign samples[1]  = frame.sample_1;
  assign samples[2]  = frame.sample_2;
  assign samples[3]  = frame.sample_3;
  assign samples[4]  = frame.sample_4;
  assign frame.ready = accept_ready;
  assign accept      = frame.valid && accept_ready;

  athd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  for (genvar g = 0; g < athd_pkg::LANES; g++) begin : g_lane
    if (g < athd_pkg::N_SENSORS) begin : g_used
      athd_lane u_lane (
        .clk       (clk),
        .rst       (rst),
        .ctrl      (lane_ctrl),
        .sample    (samples[g]),
        .threshold (cfg.threshold[g]),
        .over      (over[g])
      );
    end else begin : g_unused
      assign over[g] = 1'b0;
    end
  end

  athd_merge u_merge (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .cmd          (frame.cmd),
    .over         (over),
    .holdoff_ms   (cfg.holdoff_ms),
    .lane_ctrl    (lane_ctrl),
    .accept_ready (accept_ready),
    .result       (result)
  );

endmodule

`default_nettype wire
